// ===== hdl/est_pkg.sv =====
`default_nettype none

package est_pkg;

  localparam int EVENT_W     = 8;
  localparam int HANDLER_W   = 8;
  localparam int TAG_W       = 16;
  localparam int SLOT_W      = 4;
  localparam int OCC_W       = 5;
  localparam int CAP_W       = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int MAX_RESULTS = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MISSING_IS_ERROR = 2'd1;
  localparam logic [CAP_W-1:0]       CAPACITY_RESET       = 5'd16;

  typedef enum logic [1:0] {
    CMD_SUBSCRIBE   = 2'd0,
    CMD_UNSUBSCRIBE = 2'd1,
    CMD_DISPATCH    = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NULL_HANDLER = 3'd1,
    ST_INVALID_ARG  = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_FULL         = 3'd4,
    ST_NOT_FOUND    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_SUBSCRIBE   = 3'd0,
    OP_UNSUBSCRIBE = 3'd1,
    OP_DISPATCH    = 3'd2,
    OP_CLEAR       = 3'd3,
    OP_REJECT      = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    status_t                reject_status;
    logic [EVENT_W-1:0]     evt_id;
    logic [HANDLER_W-1:0]   handler_id;
    logic [TAG_W-1:0]       user_tag;
  } op_t;

  typedef struct packed {
    status_t                status;
    logic                   match_valid;
    logic [SLOT_W-1:0]      slot;
    logic [HANDLER_W-1:0]   handler;
    logic [TAG_W-1:0]       tag;
    logic [OCC_W-1:0]       occupancy;
    logic                   last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/est_ram.sv =====
`default_nettype none

module est_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/est_fifo.sv =====
`default_nettype none

module est_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/est_front.sv =====
`default_nettype none

module est_front #(
  parameter int EVENT_BITS = 8
) (
  input  wire logic [1:0]                     cmd,
  input  wire logic [est_pkg::EVENT_W-1:0]    evt_id,
  input  wire logic [est_pkg::HANDLER_W-1:0]  handler_id,
  input  wire logic [est_pkg::TAG_W-1:0]      user_tag,
  input  wire logic                           item_valid,
  input  wire logic                           queue_full,
  output logic                                item_stall,
  output logic                                push,
  output est_pkg::op_t                        op
);

  localparam logic [est_pkg::EVENT_W-1:0] EV_MASK =
    est_pkg::EVENT_W'((64'd1 << EVENT_BITS) - 64'd1);

  logic [est_pkg::EVENT_W-1:0] ev;

  assign ev         = evt_id & EV_MASK;
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // Checks that need no table state are settled here; the back end only
  // replays the status of a rejected transaction.
  always_comb begin
    op.kind          = est_pkg::OP_REJECT;
    op.reject_status = est_pkg::ST_OK;
    op.evt_id        = ev;
    op.handler_id    = handler_id;
    op.user_tag      = user_tag;
    unique case (est_pkg::cmd_t'(cmd))
      est_pkg::CMD_CLEAR: begin
        op.kind = est_pkg::OP_CLEAR;
      end
      est_pkg::CMD_DISPATCH: begin
        if (ev == '0) begin
          op.reject_status = est_pkg::ST_INVALID_ARG;
        end else begin
          op.kind = est_pkg::OP_DISPATCH;
        end
      end
      est_pkg::CMD_SUBSCRIBE: begin
        if (handler_id == '0) begin
          op.reject_status = est_pkg::ST_NULL_HANDLER;
        end else if (ev == '0) begin
          op.reject_status = est_pkg::ST_INVALID_ARG;
        end else begin
          op.kind = est_pkg::OP_SUBSCRIBE;
        end
      end
      est_pkg::CMD_UNSUBSCRIBE: begin
        if (handler_id == '0) begin
          op.reject_status = est_pkg::ST_NULL_HANDLER;
        end else if (ev == '0) begin
          op.reject_status = est_pkg::ST_INVALID_ARG;
        end else begin
          op.kind = est_pkg::OP_UNSUBSCRIBE;
        end
      end
      default: begin
        op.kind = est_pkg::OP_REJECT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/est_back.sv =====
`default_nettype none

module est_back #(
  parameter int SLOTS      = 16,
  parameter int EVENT_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        op_valid,
  input  wire est_pkg::op_t                op,
  output logic                             pop,
  input  wire logic [est_pkg::CAP_W-1:0]   eff_cap,
  input  wire logic                        missing_is_error,
  output logic                             res_valid,
  output est_pkg::res_t                    res,
  input  wire logic                        res_stall
);

  localparam int EW     = (EVENT_BITS < est_pkg::EVENT_W) ? EVENT_BITS : est_pkg::EVENT_W;
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EMIT_W = $clog2(est_pkg::MAX_RESULTS);
  localparam int PW     = est_pkg::HANDLER_W + est_pkg::TAG_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t                         state;
  est_pkg::op_t                   op_reg;
  logic [SLOTS-1:0]               used;
  logic [EW-1:0]                  sev  [SLOTS];
  logic [est_pkg::HANDLER_W-1:0]  shd  [SLOTS];
  logic [est_pkg::TAG_W-1:0]      stag [SLOTS];
  logic [est_pkg::OCC_W-1:0]      count;
  logic [SLOTS-1:0]               pending;
  logic [EMIT_W-1:0]              emitted;

  logic [SLOTS-1:0]               in_range;
  logic [SLOTS-1:0]               evm;
  logic [SLOTS-1:0]               exm;
  logic [SLOTS-1:0]               freev;
  logic [SLOTS-1:0]               pend_rest;
  logic [SW-1:0]                  exm_idx;
  logic [SW-1:0]                  free_idx;
  logic [SW-1:0]                  pend_idx;
  logic                           out_free;
  logic                           disp_last;
  logic                           do_sub;
  logic                           do_unsub;
  logic                           do_clear;
  logic                           go_disp;
  logic                           exec_fire;
  logic                           sub_we;
  logic                           unsub_we;
  logic                           clear_we;
  logic                           disp_fire;
  logic [PW-1:0]                  ram_rdata;
  est_pkg::res_t                  exec_res;
  est_pkg::res_t                  disp_res;

  function automatic logic [SW-1:0] first_set(input logic [SLOTS-1:0] vec);
    logic [SW-1:0] idx;
    idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (vec[k]) begin
        idx = SW'(k);
      end
    end
    return idx;
  endfunction

  // Every slot compares against the pending transaction at once.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_range[i] = (8'(i) < {3'b000, eff_cap});
      evm[i]      = used[i] && in_range[i] && (sev[i] == op_reg.evt_id[EW-1:0]);
      exm[i]      = evm[i] && (shd[i] == op_reg.handler_id) && (stag[i] == op_reg.user_tag);
      freev[i]    = !used[i] && in_range[i];
    end
  end

  assign exm_idx   = first_set(exm);
  assign free_idx  = first_set(freev);
  assign pend_idx  = first_set(pending);
  // Drops the lowest set bit, which is the match being emitted now.
  assign pend_rest = pending & (pending - 1'b1);
  assign disp_last = (pend_rest == '0) || (emitted == EMIT_W'(est_pkg::MAX_RESULTS - 1));
  assign out_free  = !res_valid || !res_stall;
  assign pop       = (state == S_IDLE) && op_valid;

  always_comb begin
    exec_res.status      = est_pkg::ST_OK;
    exec_res.match_valid = 1'b0;
    exec_res.slot        = '0;
    exec_res.handler     = '0;
    exec_res.tag         = '0;
    exec_res.occupancy   = count;
    exec_res.last        = 1'b1;
    do_sub   = 1'b0;
    do_unsub = 1'b0;
    do_clear = 1'b0;
    go_disp  = 1'b0;
    unique case (op_reg.kind)
      est_pkg::OP_REJECT: begin
        exec_res.status = op_reg.reject_status;
      end
      est_pkg::OP_CLEAR: begin
        do_clear           = 1'b1;
        exec_res.occupancy = '0;
      end
      est_pkg::OP_DISPATCH: begin
        if (evm != '0) begin
          go_disp = 1'b1;
        end else if (missing_is_error) begin
          exec_res.status = est_pkg::ST_NOT_FOUND;
        end
      end
      est_pkg::OP_SUBSCRIBE: begin
        if (exm != '0) begin
          exec_res.status = est_pkg::ST_DUPLICATE;
        end else if (count >= eff_cap) begin
          exec_res.status = est_pkg::ST_FULL;
        end else if (freev != '0) begin
          do_sub             = 1'b1;
          exec_res.slot      = est_pkg::SLOT_W'(free_idx);
          exec_res.occupancy = count + 1'b1;
        end else begin
          exec_res.status = est_pkg::ST_FULL;
        end
      end
      est_pkg::OP_UNSUBSCRIBE: begin
        if (exm != '0) begin
          do_unsub           = 1'b1;
          exec_res.slot      = est_pkg::SLOT_W'(exm_idx);
          exec_res.occupancy = count - 1'b1;
        end else begin
          exec_res.status = est_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        exec_res.status = est_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    disp_res.status      = est_pkg::ST_OK;
    disp_res.match_valid = 1'b1;
    disp_res.slot        = est_pkg::SLOT_W'(pend_idx);
    disp_res.handler     = ram_rdata[PW-1:est_pkg::TAG_W];
    disp_res.tag         = ram_rdata[est_pkg::TAG_W-1:0];
    disp_res.occupancy   = count;
    disp_res.last        = disp_last;
  end

  assign exec_fire = (state == S_EXEC) && !go_disp && out_free;
  assign sub_we    = exec_fire && do_sub;
  assign unsub_we  = exec_fire && do_unsub;
  assign clear_we  = exec_fire && do_clear;
  assign disp_fire = (state == S_WR) && out_free;

  // Handler and tag are mirrored here so that a dispatch reads them by slot.
  est_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_payload (
    .clk   (clk),
    .we    (sub_we),
    .waddr (free_idx),
    .wdata ({op_reg.handler_id, op_reg.user_tag}),
    .raddr (pend_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (sub_we && (free_idx == SW'(i))) begin
        sev[i]  <= op_reg.evt_id[EW-1:0];
        shd[i]  <= op_reg.handler_id;
        stag[i] <= op_reg.user_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else if (clear_we) begin
      used  <= '0;
      count <= '0;
    end else if (sub_we) begin
      used[free_idx] <= 1'b1;
      count          <= count + 1'b1;
    end else if (unsub_we) begin
      used[exm_idx] <= 1'b0;
      count         <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_reg <= op;
    end
    if ((state == S_EXEC) && go_disp) begin
      pending <= evm;
      emitted <= '0;
    end else if (disp_fire) begin
      pending <= pend_rest;
      emitted <= emitted + 1'b1;
    end
    if (exec_fire) begin
      res <= exec_res;
    end else if (disp_fire) begin
      res <= disp_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (exec_fire || disp_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go_disp) begin
            state <= S_RD;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (out_free) begin
            state <= disp_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/event_subscription_table.sv =====
// Channel    Direction  Handshake               Payload
// item       in         item_valid/item_stall   cmd, evt_id, handler_id, user_tag
// result     out        result_valid/result_stall
//                                               status, match_valid, slot, out_handler,
//                                               out_tag, occupancy, last
// cfg        in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A transaction with a single result is first taken from the two-entry queue by the
// table sequencer, then the parallel slot compare and update run and load the result.
// A dispatch with N matches (at most 16 emitted) then costs, for each match, a
// registered read of the handler/tag RAM and one output load.
// Reset empties the table at once (no clearing pass); capacity returns to 16.
// The queue keeps accepting items while the result register is stalled, until both entries are full.

`default_nettype none

module event_subscription_table #(
  parameter int SLOTS      = 16,
  parameter int EVENT_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic [1:0]                         cmd,
  input  wire logic [est_pkg::EVENT_W-1:0]        evt_id,
  input  wire logic [est_pkg::HANDLER_W-1:0]      handler_id,
  input  wire logic [est_pkg::TAG_W-1:0]          user_tag,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic [2:0]                              status,
  output logic                                    match_valid,
  output logic [est_pkg::SLOT_W-1:0]              slot,
  output logic [est_pkg::HANDLER_W-1:0]           out_handler,
  output logic [est_pkg::TAG_W-1:0]               out_tag,
  output logic [est_pkg::OCC_W-1:0]               occupancy,
  output logic                                    last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [est_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [est_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OPW = $bits(est_pkg::op_t);

  logic [est_pkg::CAP_W-1:0] capacity;
  logic                      missing_is_error;
  logic [est_pkg::CAP_W-1:0] eff_cap;
  logic                      queue_full;
  logic                      queue_empty;
  logic                      push;
  logic                      pop;
  logic [OPW-1:0]            queue_head;
  est_pkg::op_t              front_op;
  est_pkg::res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= est_pkg::CAPACITY_RESET;
      missing_is_error <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == est_pkg::REG_CAPACITY) begin
        capacity <= cfg_data;
      end else if (cfg_index == est_pkg::REG_MISSING_IS_ERROR) begin
        missing_is_error <= cfg_data[0];
      end
    end
  end

  // A capacity above the table size is clamped to it.
  assign eff_cap = ({3'b000, capacity} < 8'(SLOTS)) ? capacity : est_pkg::CAP_W'(SLOTS);

  est_front #(
    .EVENT_BITS (EVENT_BITS)
  ) u_front (
    .cmd        (cmd),
    .evt_id     (evt_id),
    .handler_id (handler_id),
    .user_tag   (user_tag),
    .item_valid (item_valid),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .op         (front_op)
  );

  est_fifo #(
    .WIDTH (OPW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_op),
    .pop   (pop),
    .rdata (queue_head),
    .full  (queue_full),
    .empty (queue_empty)
  );

  est_back #(
    .SLOTS      (SLOTS),
    .EVENT_BITS (EVENT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .op_valid         (!queue_empty),
    .op               (est_pkg::op_t'(queue_head)),
    .pop              (pop),
    .eff_cap          (eff_cap),
    .missing_is_error (missing_is_error),
    .res_valid        (result_valid),
    .res              (res),
    .res_stall        (result_stall)
  );

  assign status      = res.status;
  assign match_valid = res.match_valid;
  assign slot        = res.slot;
  assign out_handler = res.handler;
  assign out_tag     = res.tag;
  assign occupancy   = res.occupancy;
  assign last        = res.last;

  // A matched subscription is only ever reported with an ok status.
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && match_valid |-> status == est_pkg::ST_OK)
    else $error("matched result with non-ok status");

  // Only a dispatch fans out, so every result short of the last carries a match.
  a_fanout_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> match_valid)
    else $error("non-final result without a match");

  // A rejected or failed transaction yields exactly one bare result.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != est_pkg::ST_OK |-> !match_valid && last && slot == '0)
    else $error("error result is not a single bare result");

endmodule

`default_nettype wire

// ===== sim/tb_event_subscription_table.sv =====
`timescale 1ns / 100ps

module tb_event_subscription_table;

  localparam int TABLE_SLOTS      = 16;
  localparam int CYCLE_LIMIT      = 900000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 56;
  localparam int SETTLE_CYCLES    = 8;

  // Indexes past the two real registers; writes to them must change nothing.
  localparam logic [est_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [est_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  class slot_table_model;
    logic [est_pkg::CAP_W-1:0]     capacity;
    logic                          missing_is_error;
    logic                          used   [TABLE_SLOTS];
    logic [est_pkg::EVENT_W-1:0]   ev_of  [TABLE_SLOTS];
    logic [est_pkg::HANDLER_W-1:0] h_of   [TABLE_SLOTS];
    logic [est_pkg::TAG_W-1:0]     tag_of [TABLE_SLOTS];
    logic [est_pkg::OCC_W-1:0]     count;
    est_pkg::res_t                 due_results [$];
    int                            failures;
    int                            commands;
    int                            results;
    int                            status_seen [6];
    int                            widest_fanout;

    function new();
      capacity = est_pkg::CAPACITY_RESET;
      missing_is_error = 1'b0;
      failures = 0;
      commands = 0;
      results = 0;
      widest_fanout = 0;
      for (int i = 0; i < 6; i++) status_seen[i] = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        used[i] = 1'b0;
        ev_of[i] = '0;
        h_of[i] = '0;
        tag_of[i] = '0;
      end
      count = '0;
    endfunction

    function void set_reg(logic [est_pkg::CFG_INDEX_W-1:0] idx,
                          logic [est_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        est_pkg::REG_CAPACITY:         capacity = data;
        est_pkg::REG_MISSING_IS_ERROR: missing_is_error = data[0];
        default: ;
      endcase
    endfunction

    function void push(est_pkg::status_t st, logic mv, int s,
                       logic [est_pkg::HANDLER_W-1:0] h,
                       logic [est_pkg::TAG_W-1:0] t, logic lst);
      est_pkg::res_t r;
      r.status = st;
      r.match_valid = mv;
      r.slot = est_pkg::SLOT_W'(s);
      r.handler = h;
      r.tag = t;
      r.occupancy = count;
      r.last = lst;
      due_results.push_back(r);
    endfunction

    function int find_exact(int cap, logic [est_pkg::EVENT_W-1:0] ev,
                            logic [est_pkg::HANDLER_W-1:0] h,
                            logic [est_pkg::TAG_W-1:0] t);
      for (int i = 0; i < cap; i++)
        if (used[i] && ev_of[i] == ev && h_of[i] == h && tag_of[i] == t) return i;
      return -1;
    endfunction

    function void take_command(est_pkg::cmd_t c, logic [est_pkg::EVENT_W-1:0] ev,
                               logic [est_pkg::HANDLER_W-1:0] h,
                               logic [est_pkg::TAG_W-1:0] t);
      int cap;
      int hits;
      int k;
      int s;
      cap = (capacity < TABLE_SLOTS) ? int'(capacity) : TABLE_SLOTS;
      commands++;
      if (c == est_pkg::CMD_CLEAR) begin
        wipe();
        push(est_pkg::ST_OK, 1'b0, 0, '0, '0, 1'b1);
      end else if (c == est_pkg::CMD_DISPATCH) begin
        if (ev == '0) begin
          push(est_pkg::ST_INVALID_ARG, 1'b0, 0, '0, '0, 1'b1);
        end else begin
          hits = 0;
          for (int i = 0; i < cap; i++)
            if (used[i] && ev_of[i] == ev) hits++;
          if (hits > est_pkg::MAX_RESULTS) hits = est_pkg::MAX_RESULTS;
          if (hits == 0) begin
            push(missing_is_error ? est_pkg::ST_NOT_FOUND : est_pkg::ST_OK,
                 1'b0, 0, '0, '0, 1'b1);
          end else begin
            k = 0;
            for (int i = 0; i < cap && k < hits; i++) begin
              if (used[i] && ev_of[i] == ev) begin
                k++;
                push(est_pkg::ST_OK, 1'b1, i, h_of[i], tag_of[i], k == hits);
              end
            end
            if (hits > widest_fanout) widest_fanout = hits;
          end
        end
      end else if (h == '0) begin
        // A null handler is reported ahead of a zero event id.
        push(est_pkg::ST_NULL_HANDLER, 1'b0, 0, '0, '0, 1'b1);
      end else if (ev == '0) begin
        push(est_pkg::ST_INVALID_ARG, 1'b0, 0, '0, '0, 1'b1);
      end else if (c == est_pkg::CMD_SUBSCRIBE) begin
        if (find_exact(cap, ev, h, t) >= 0) begin
          push(est_pkg::ST_DUPLICATE, 1'b0, 0, '0, '0, 1'b1);
        end else if (count >= cap) begin
          push(est_pkg::ST_FULL, 1'b0, 0, '0, '0, 1'b1);
        end else begin
          s = -1;
          for (int i = 0; i < cap; i++)
            if (!used[i] && s < 0) s = i;
          if (s < 0) begin
            push(est_pkg::ST_FULL, 1'b0, 0, '0, '0, 1'b1);
          end else begin
            used[s] = 1'b1;
            ev_of[s] = ev;
            h_of[s] = h;
            tag_of[s] = t;
            count = count + 1'b1;
            push(est_pkg::ST_OK, 1'b0, s, '0, '0, 1'b1);
          end
        end
      end else begin
        s = find_exact(cap, ev, h, t);
        if (s < 0) begin
          push(est_pkg::ST_NOT_FOUND, 1'b0, 0, '0, '0, 1'b1);
        end else begin
          used[s] = 1'b0;
          ev_of[s] = '0;
          h_of[s] = '0;
          tag_of[s] = '0;
          count = count - 1'b1;
          push(est_pkg::ST_OK, 1'b0, s, '0, '0, 1'b1);
        end
      end
    endfunction

    function string show(est_pkg::res_t r);
      return $sformatf("status=%0d match=%0b slot=%0d handler=%02h tag=%04h occ=%0d last=%0b",
                       r.status, r.match_valid, r.slot, r.handler, r.tag, r.occupancy,
                       r.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= SHOWN_MISMATCHES) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(est_pkg::res_t got);
      est_pkg::res_t want;
      results++;
      if (due_results.size() == 0) begin
        note_failure($sformatf("result with nothing outstanding: %s", show(got)));
        return;
      end
      want = due_results.pop_front();
      if (int'(want.status) < 6) status_seen[want.status]++;
      if (got.status !== want.status || got.match_valid !== want.match_valid ||
          got.slot !== want.slot || got.handler !== want.handler ||
          got.tag !== want.tag || got.occupancy !== want.occupancy ||
          got.last !== want.last)
        note_failure($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  est_pkg::cmd_t                   cmd = est_pkg::CMD_SUBSCRIBE;
  logic [est_pkg::EVENT_W-1:0]     evt_id = '0;
  logic [est_pkg::HANDLER_W-1:0]   handler_id = '0;
  logic [est_pkg::TAG_W-1:0]       user_tag = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic [2:0]                      status;
  logic                            match_valid;
  logic [est_pkg::SLOT_W-1:0]      slot;
  logic [est_pkg::HANDLER_W-1:0]   out_handler;
  logic [est_pkg::TAG_W-1:0]       out_tag;
  logic [est_pkg::OCC_W-1:0]       occupancy;
  logic                            last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [est_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [est_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  slot_table_model                 tbl;
  int                              cycles = 0;
  int                              items_sent = 0;
  int                              settings_used = 0;
  int                              stall_left = 0;
  bit                              no_idle = 1'b0;
  est_pkg::res_t                   got_r;
  logic [est_pkg::EVENT_W-1:0]     ev_pool  [4];
  logic [est_pkg::HANDLER_W-1:0]   h_pool   [4];
  logic [est_pkg::TAG_W-1:0]       tag_pool [3];

  event_subscription_table i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .evt_id(evt_id),
    .handler_id(handler_id),
    .user_tag(user_tag),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .match_valid(match_valid),
    .slot(slot),
    .out_handler(out_handler),
    .out_tag(out_tag),
    .occupancy(occupancy),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Result side: check every accepted transaction, then choose the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got_r.status = est_pkg::status_t'(status);
        got_r.match_valid = match_valid;
        got_r.slot = slot;
        got_r.handler = out_handler;
        got_r.tag = out_tag;
        got_r.occupancy = occupancy;
        got_r.last = last;
        tbl.check_result(got_r);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(est_pkg::cmd_t c, logic [est_pkg::EVENT_W-1:0] ev,
                           logic [est_pkg::HANDLER_W-1:0] h,
                           logic [est_pkg::TAG_W-1:0] t);
    int gap;
    cmd <= c;
    evt_id <= ev;
    handler_id <= h;
    user_tag <= t;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    tbl.take_command(c, ev, h, t);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tbl.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [est_pkg::CFG_INDEX_W-1:0] idx,
                           logic [est_pkg::CFG_DATA_W-1:0] data, bit keep);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tbl.set_reg(idx, data);
    if (!keep) cfg_valid <= 1'b0;
  endtask

  task automatic configure(int cap, bit mie);
    logic [est_pkg::CFG_DATA_W-2:0] junk;
    junk = (est_pkg::CFG_DATA_W - 1)'($urandom);
    write_reg(est_pkg::REG_CAPACITY, est_pkg::CFG_DATA_W'(cap), 1'b1);
    // Only bit 0 of the error-mode register matters; the rest carry noise.
    write_reg(est_pkg::REG_MISSING_IS_ERROR, {junk, mie}, 1'b0);
    settings_used++;
  endtask

  task automatic rand_item();
    int r;
    int j;
    int picks [$];
    est_pkg::cmd_t c;
    logic [est_pkg::EVENT_W-1:0] ev;
    logic [est_pkg::HANDLER_W-1:0] h;
    logic [est_pkg::TAG_W-1:0] t;
    ev = ($urandom_range(0, 4) == 0) ? est_pkg::EVENT_W'($urandom_range(0, 255))
                                     : ev_pool[$urandom_range(0, 3)];
    r = $urandom_range(0, 99);
    if (r < 5) h = '0;
    else if (r < 15) h = est_pkg::HANDLER_W'($urandom_range(1, 255));
    else h = h_pool[$urandom_range(0, 3)];
    t = ($urandom_range(0, 1) == 0) ? tag_pool[$urandom_range(0, 2)]
                                    : est_pkg::TAG_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 38) begin
      c = est_pkg::CMD_SUBSCRIBE;
    end else if (r < 60) begin
      c = est_pkg::CMD_UNSUBSCRIBE;
      // Most unsubscribes name a live subscription exactly.
      if ($urandom_range(0, 9) < 7) begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tbl.used[i]) picks.push_back(i);
        if (picks.size() > 0) begin
          j = picks[$urandom_range(0, picks.size() - 1)];
          ev = tbl.ev_of[j];
          h = tbl.h_of[j];
          t = tbl.tag_of[j];
        end
      end
    end else if (r < 95) begin
      c = est_pkg::CMD_DISPATCH;
    end else begin
      c = est_pkg::CMD_CLEAR;
    end
    send_item(c, ev, h, t);
  endtask

  // Fill the table with one event and dispatch it, for the widest fan-out.
  task automatic burst();
    send_item(est_pkg::CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < TABLE_SLOTS; i++)
      send_item(est_pkg::CMD_SUBSCRIBE, ev_pool[0], est_pkg::HANDLER_W'(i + 1),
                est_pkg::TAG_W'($urandom));
    send_item(est_pkg::CMD_DISPATCH, ev_pool[0], '0, '0);
  endtask

  initial begin
    int phase_cap [PHASES];
    int start;
    tbl = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    configure(est_pkg::CAPACITY_RESET, 1'b0);
    send_item(est_pkg::CMD_DISPATCH, 8'h00, 8'h12, 16'h0000);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h00, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h00, 8'h05, 16'h1234);
    send_item(est_pkg::CMD_UNSUBSCRIBE, 8'h00, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_UNSUBSCRIBE, 8'h00, 8'h01, 16'h0000);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'hff, 8'hff, 16'hffff);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'hff, 8'hff, 16'hffff);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'hff, 8'h01, 16'h0000);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h01, 8'h80, 16'h8000);
    send_item(est_pkg::CMD_DISPATCH, 8'hff, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_UNSUBSCRIBE, 8'hff, 8'hff, 16'hffff);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'hff, 8'h55, 16'haaaa);
    send_item(est_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000);

    drain();
    configure(3, 1'b1);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h2a, 8'h11, 16'h0001);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h2a, 8'h22, 16'h0002);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h2a, 8'h33, 16'h0003);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h2a, 8'h44, 16'h0004);
    send_item(est_pkg::CMD_DISPATCH, 8'h2a, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_DISPATCH, 8'h33, 8'h00, 16'h0000);
    // Capacity now sits below the occupied slots.
    drain();
    configure(1, 1'b1);
    send_item(est_pkg::CMD_DISPATCH, 8'h2a, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h2b, 8'h01, 16'h0000);
    send_item(est_pkg::CMD_UNSUBSCRIBE, 8'h2a, 8'h22, 16'h0002);
    drain();
    configure(0, 1'b0);
    send_item(est_pkg::CMD_SUBSCRIBE, 8'h05, 8'h05, 16'h0005);
    send_item(est_pkg::CMD_DISPATCH, 8'h2a, 8'h00, 16'h0000);
    send_item(est_pkg::CMD_UNSUBSCRIBE, 8'h2a, 8'h11, 16'h0001);
    send_item(est_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000);

    phase_cap = '{16, 3, 31, 0, 1, $urandom_range(2, 15), 16, $urandom_range(17, 30)};
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(phase_cap[p], (p % 2) == 1);
      if (p == PHASES - 1) begin
        write_reg(REG_SPARE_A, est_pkg::CFG_DATA_W'($urandom), 1'b1);
        write_reg(REG_SPARE_B, est_pkg::CFG_DATA_W'($urandom), 1'b0);
      end
      for (int i = 0; i < 4; i++) begin
        ev_pool[i] = est_pkg::EVENT_W'($urandom_range(1, 255));
        h_pool[i] = est_pkg::HANDLER_W'($urandom_range(1, 255));
      end
      for (int i = 0; i < 3; i++) tag_pool[i] = est_pkg::TAG_W'($urandom);
      start = items_sent;
      if (p == 0 || $urandom_range(0, 2) == 0) burst();
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
        // Hold the sender off until the table has answered everything.
        if (items_sent - start == PHASE_ITEMS / 2) drain();
        rand_item();
      end
      no_idle = 1'b0;
    end

    drain();
    if (tbl.due_results.size() != 0)
      tbl.note_failure($sformatf("%0d results never arrived", tbl.due_results.size()));
    if (tbl.failures > SHOWN_MISMATCHES)
      $display("%0d further mismatches were counted but not shown",
               tbl.failures - SHOWN_MISMATCHES);
    $display("Ran %0d commands giving %0d results across %0d register settings; widest %s %0d.",
             tbl.commands, tbl.results, settings_used, "dispatch fan-out", tbl.widest_fanout);
    $display("Outcomes: ok %0d, null handler %0d, invalid %0d, duplicate %0d, full %0d, %s %0d.",
             tbl.status_seen[0], tbl.status_seen[1], tbl.status_seen[2],
             tbl.status_seen[3], tbl.status_seen[4], "not found", tbl.status_seen[5]);
    if (tbl.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
